// ===== src/vrf_pkg.sv =====
// Shared widths, constants and control types for the vertical resize filter.
// Used by the channel interfaces, the accumulator lane and the top level.
`default_nettype none

package vrf_pkg;

    localparam int SAMPLE_W = 14;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 16;

    // Upper output limit: full scale less a rounding margin
    localparam logic [SUM_W-1:0] CLAMP_HIGH = SUM_W'(16383 - 42);

    // Control from the top level to each accumulator lane
    typedef struct packed {
        logic advance;  // stage one item moves on this cycle
        logic last;     // that item closes the output pixel
    } acc_ctrl_t;

endpackage

`default_nettype wire

// ===== src/vrf_tap_if.sv =====
// Input channel: one source row's RGB samples and its kernel weight per transaction.
// Depends on vrf_pkg for the field widths.
`default_nettype none

interface vrf_tap_if;
    logic                                 valid;
    logic                                 ready;
    logic        [vrf_pkg::SAMPLE_W-1:0] red_sample;
    logic        [vrf_pkg::SAMPLE_W-1:0] green_sample;
    logic        [vrf_pkg::SAMPLE_W-1:0] blue_sample;
    logic signed [vrf_pkg::WEIGHT_W-1:0] tap_weight;
    logic                                 last_tap;

    modport source (
        output valid, red_sample, green_sample, blue_sample, tap_weight, last_tap,
        input  ready
    );

    modport sink (
        input  valid, red_sample, green_sample, blue_sample, tap_weight, last_tap,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/vrf_pix_if.sv =====
// Output channel: one filtered RGB pixel per transaction.
// Depends on vrf_pkg for the field widths.
`default_nettype none

interface vrf_pix_if;
    logic                          valid;
    logic                          ready;
    logic [vrf_pkg::SAMPLE_W-1:0] red_out;
    logic [vrf_pkg::SAMPLE_W-1:0] green_out;
    logic [vrf_pkg::SAMPLE_W-1:0] blue_out;

    modport source (
        output valid, red_out, green_out, blue_out,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/vertical_resize_filter_fixed.sv =====
// Vertical resize filter top level: input register, three colour lanes, result register.
// Depends on vrf_pkg, vrf_tap_if, vrf_pix_if and vrf_lane.
//
// Usage
//   tap_in carries one source row per transaction: the red, green and blue samples
//   and the signed kernel weight for that row (16384 is unity). Each transaction
//   adds weight * sample to a saturating 16-bit sum per colour. A transaction with
//   last_tap high closes the output pixel: its sums, this tap included, are
//   clamped to 0..16341 and sent on pix_out as one transaction, and the sums clear.
//   Transactions without last_tap produce nothing on pix_out.
// Throughput and pipeline
//   One transaction per cycle is accepted unless a closing tap is held (see Stalls).
//   A tap is captured in the input register when accepted and folded into the sums
//   as it advances, where a closing tap also loads the result register, from which
//   the pixel is offered on pix_out. The per-cycle work is one 16x16 multiply, one
//   saturating add and the clamp in each lane.
// Reset
//   rst_n clears the sums and both valid flags; no pixel is pending afterwards.
// Stalls
//   While pix_out is held off, a pixel waits in the result register. Taps that do
//   not close a pixel keep flowing; a closing tap waits in the input register until
//   the result register frees, and tap_in.ready drops only then.
`default_nettype none

module vertical_resize_filter_fixed (
    input  wire logic clk,
    input  wire logic rst_n,
    vrf_tap_if.sink   tap_in,
    vrf_pix_if.source pix_out
);

    // Input register
    logic                                 s1_valid_reg;
    logic                                 s1_valid_next;
    logic        [vrf_pkg::SAMPLE_W-1:0] s1_red_reg;
    logic        [vrf_pkg::SAMPLE_W-1:0] s1_green_reg;
    logic        [vrf_pkg::SAMPLE_W-1:0] s1_blue_reg;
    logic signed [vrf_pkg::WEIGHT_W-1:0] s1_weight_reg;
    logic                                 s1_last_reg;

    // Result register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [vrf_pkg::SAMPLE_W-1:0] red_out_reg;
    logic [vrf_pkg::SAMPLE_W-1:0] green_out_reg;
    logic [vrf_pkg::SAMPLE_W-1:0] blue_out_reg;

    logic [vrf_pkg::SAMPLE_W-1:0] red_res;
    logic [vrf_pkg::SAMPLE_W-1:0] green_res;
    logic [vrf_pkg::SAMPLE_W-1:0] blue_res;

    vrf_pkg::acc_ctrl_t acc_ctrl;
    logic               out_free;
    logic               tap_accept;
    logic               pix_load;

    // The result register is free if empty or being drained this cycle
    assign out_free       = !out_valid_reg || pix_out.ready;
    // Advance the staged tap unless it closes a pixel and the result slot is held
    assign acc_ctrl.advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign acc_ctrl.last    = s1_last_reg;
    assign pix_load       = acc_ctrl.advance && s1_last_reg;

    assign tap_in.ready   = !s1_valid_reg || acc_ctrl.advance;
    assign tap_accept     = tap_in.valid && tap_in.ready;

    assign s1_valid_next  = tap_accept || (s1_valid_reg && !acc_ctrl.advance);
    assign out_valid_next = pix_load || (out_valid_reg && !pix_out.ready);

    vrf_lane u_red (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .sample (s1_red_reg),
        .weight (s1_weight_reg),
        .result (red_res)
    );

    vrf_lane u_green (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .sample (s1_green_reg),
        .weight (s1_weight_reg),
        .result (green_res)
    );

    vrf_lane u_blue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .sample (s1_blue_reg),
        .weight (s1_weight_reg),
        .result (blue_res)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture a tap on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (tap_accept)
        begin
            s1_red_reg    <= tap_in.red_sample;
            s1_green_reg  <= tap_in.green_sample;
            s1_blue_reg   <= tap_in.blue_sample;
            s1_weight_reg <= tap_in.tap_weight;
            s1_last_reg   <= tap_in.last_tap;
        end
    end

    // Load the clamped pixel when a closing tap is folded in
    always_ff @(posedge clk)
    begin
        if (pix_load)
        begin
            red_out_reg   <= red_res;
            green_out_reg <= green_res;
            blue_out_reg  <= blue_res;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = red_out_reg;
    assign pix_out.green_out = green_out_reg;
    assign pix_out.blue_out  = blue_out_reg;

    // A closing tap must never overwrite a pixel that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(pix_load && out_valid_reg && !pix_out.ready))
        else $error("closing tap advanced over a held pixel");

    // Folding in a closing tap offers a pixel at the next edge
    a_pix_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pix_load |=> pix_out.valid)
        else $error("closing tap produced no pixel");

    // Non-closing taps are never held back by the output side
    a_open_tap_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_last_reg) |-> tap_in.ready)
        else $error("non-closing tap stalled");

    // Offered pixels stay within the clamp range
    a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid |-> ({2'b00, pix_out.red_out} <= vrf_pkg::CLAMP_HIGH &&
                           {2'b00, pix_out.green_out} <= vrf_pkg::CLAMP_HIGH &&
                           {2'b00, pix_out.blue_out} <= vrf_pkg::CLAMP_HIGH))
        else $error("pixel outside clamp range");

endmodule

`default_nettype wire

// ===== src/vrf_lane.sv =====
// One colour lane: weighted tap term, saturating accumulator and output clamp.
// Depends on vrf_pkg for widths, the clamp limit and the control struct.
`default_nettype none

module vrf_lane (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire vrf_pkg::acc_ctrl_t                   ctrl,
    input  wire logic        [vrf_pkg::SAMPLE_W-1:0] sample,
    input  wire logic signed [vrf_pkg::WEIGHT_W-1:0] weight,
    output      logic        [vrf_pkg::SAMPLE_W-1:0] result
);

    logic signed [vrf_pkg::SUM_W-1:0]                    sum_reg;
    logic signed [vrf_pkg::SUM_W-1:0]                    sum_next;
    logic signed [vrf_pkg::SUM_W-1:0]                    sample_x2;
    logic signed [vrf_pkg::SUM_W+vrf_pkg::WEIGHT_W-1:0] product;
    logic signed [vrf_pkg::SUM_W-1:0]                    term;
    logic signed [vrf_pkg::SUM_W:0]                      wide_sum;
    logic signed [vrf_pkg::SUM_W-1:0]                    sat_sum;

    // Doubled sample never reaches the sign bit
    assign sample_x2 = {1'b0, sample, 1'b0};
    assign product   = sample_x2 * weight;
    // Keep the high half and double it again, wrapping to the sum width
    assign term      = {product[vrf_pkg::SUM_W+vrf_pkg::WEIGHT_W-2:vrf_pkg::WEIGHT_W], 1'b0};
    assign wide_sum  = {sum_reg[vrf_pkg::SUM_W-1], sum_reg} + {term[vrf_pkg::SUM_W-1], term};

    always_comb
    begin
        if (wide_sum[vrf_pkg::SUM_W] != wide_sum[vrf_pkg::SUM_W-1])
        begin
            // Overflow: pin to the most negative or most positive value
            sat_sum = {wide_sum[vrf_pkg::SUM_W], {(vrf_pkg::SUM_W-1){~wide_sum[vrf_pkg::SUM_W]}}};
        end
        else
        begin
            sat_sum = wide_sum[vrf_pkg::SUM_W-1:0];
        end
    end

    always_comb
    begin
        if (sat_sum[vrf_pkg::SUM_W-1])
        begin
            result = '0;
        end
        else if (unsigned'(sat_sum) > vrf_pkg::CLAMP_HIGH)
        begin
            result = vrf_pkg::CLAMP_HIGH[vrf_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            result = sat_sum[vrf_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (ctrl.advance)
        begin
            sum_next = ctrl.last ? '0 : sat_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire
